>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define USP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("usp assertion failed");

// next-cycle implication under synchronous reset
`define USP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("usp assertion failed");

`endif

>>> rtl/usp_pkg.sv
// shared constants, types and small tables of the uv sphere vertex block
// no dependencies
`default_nettype none

package usp_pkg;

   localparam int MAX_SLICES  = 256;
   localparam int MAX_STACKS  = 256;
   localparam int STACK_LIMIT = (MAX_STACKS < 511) ? MAX_STACKS : 511;
   localparam int COUNT_W     = 9;
   localparam int TABLE_DEPTH = ((MAX_SLICES > STACK_LIMIT) ? MAX_SLICES : STACK_LIMIT) + 1;
   localparam int TAB_AW      = $clog2(TABLE_DEPTH);

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [15:0] HALF_PI_LO  = HALF_PI_Q30[15:0];
   localparam logic [14:0] HALF_PI_HI  = HALF_PI_Q30[30:16];
   localparam logic [32:0] ONE_Q30     = 33'd1073741824;

   localparam int DIV_W      = 44;
   localparam int DIV_DEN_W  = 10;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [3:0] SERIES_TERMS = 4'd9;

   localparam int FACE_Q_DEPTH = 2;
   localparam int FACE_Q_AW    = 1;
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_AW       = 3;
   localparam int OUT_CW       = 4;

   localparam logic [2:0] FIRST_SLOT = 3'd0;
   localparam logic [2:0] LAST_SLOT  = 3'd5;
   localparam int SLOT_LSB = 133;

   typedef enum logic [1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SLICES = 2'd1,
      CSR_STACKS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] x;
   } face_type;

   typedef struct packed {
      logic     valid;
      face_type face;
   } face_q_type;

   typedef struct packed {
      logic        sin_neg;
      logic [30:0] sin_mag;
      logic        cos_neg;
      logic [30:0] cos_mag;
      logic [16:0] tex;
   } table_entry_type;

   localparam int ENTRY_W = $bits(table_entry_type);

   typedef struct packed {
      logic              theta_we;
      logic              phi_we;
      logic [TAB_AW-1:0] addr;
      table_entry_type   data;
   } table_write_type;

   typedef struct packed {
      logic        last;
      logic [2:0]  slot;
      logic [15:0] norm_z;
      logic [15:0] norm_y;
      logic [15:0] norm_x;
      logic [16:0] tex_v;
      logic [16:0] tex_u;
      logic [16:0] pos_z;
      logic [16:0] pos_y;
      logic [16:0] pos_x;
   } rsp_type;

   // corner offsets of the two triangles
   function automatic logic corner_dx(input logic [2:0] slot);
      case (slot)
         3'd1, 3'd3, 3'd5: corner_dx = 1'b1;
         default:          corner_dx = 1'b0;
      endcase
   endfunction

   function automatic logic corner_dy(input logic [2:0] slot);
      case (slot)
         3'd0, 3'd4, 3'd5: corner_dy = 1'b1;
         default:          corner_dy = 1'b0;
      endcase
   endfunction

   // taylor denominators (2n)(2n+1) for sine
   function automatic logic [DIV_DEN_W-1:0] sin_divisor(input logic [3:0] n);
      case (n)
         4'd1:    sin_divisor = 10'd6;
         4'd2:    sin_divisor = 10'd20;
         4'd3:    sin_divisor = 10'd42;
         4'd4:    sin_divisor = 10'd72;
         4'd5:    sin_divisor = 10'd110;
         4'd6:    sin_divisor = 10'd156;
         4'd7:    sin_divisor = 10'd210;
         4'd8:    sin_divisor = 10'd272;
         4'd9:    sin_divisor = 10'd342;
         default: sin_divisor = 10'd1;
      endcase
   endfunction

   // taylor denominators (2n-1)(2n) for cosine
   function automatic logic [DIV_DEN_W-1:0] cos_divisor(input logic [3:0] n);
      case (n)
         4'd1:    cos_divisor = 10'd2;
         4'd2:    cos_divisor = 10'd12;
         4'd3:    cos_divisor = 10'd30;
         4'd4:    cos_divisor = 10'd56;
         4'd5:    cos_divisor = 10'd90;
         4'd6:    cos_divisor = 10'd132;
         4'd7:    cos_divisor = 10'd182;
         4'd8:    cos_divisor = 10'd240;
         4'd9:    cos_divisor = 10'd306;
         default: cos_divisor = 10'd1;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> rtl/uv_sphere_face_vertex_generator.sv
// uv sphere face vertex generator, top level; uses usp_pkg and usp_* design modules
// face items pass the face queue, table read, product registers and output queue
// throughput: one vertex per cycle while the output queue has room, six per face item,
//    set by the one read port of each angle table; a new item is taken while earlier
//    vertices drain; reset and every slice or stack count write rebuild both angle
//    tables, (slices + 1) + (stacks + 1) entries, before vertices flow
`default_nettype none

module uv_sphere_face_vertex_generator import usp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: slice_index [7:0], stack_index [15:8]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,
   // result: pos_x [16:0], pos_y [33:17], pos_z [50:34], tex_u [67:51],
   //    tex_v [84:68], norm_x [100:85], norm_y [116:101], norm_z [132:117],
   //    vertex_slot [135:133]; tlast is last_vertex
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tlast,
   // register writes: radius, slice count, stack count
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   logic [15:0]        radius_ff;
   logic [COUNT_W-1:0] slices_ff;
   logic [COUNT_W-1:0] stacks_ff;
   logic [COUNT_W-1:0] ns, nt;
   logic               rebuild;

   table_write_type    tab_wr;
   logic               tables_ready;
   face_q_type         face_head;
   logic               face_pop;
   logic [TAB_AW-1:0]  theta_raddr, phi_raddr;
   logic [ENTRY_W-1:0] theta_rbits, phi_rbits;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         slices_ff <= COUNT_W'(16);
         stacks_ff <= COUNT_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_SLICES: slices_ff <= csr_wdata[COUNT_W-1:0];
            CSR_STACKS: stacks_ff <= csr_wdata[COUNT_W-1:0];
            default:    radius_ff <= radius_ff;
         endcase
      end
   end

   // counts saturate to one and to 256, one below the table depth
   assign ns = (slices_ff == '0) ? COUNT_W'(1) :
               (slices_ff > COUNT_W'(MAX_SLICES)) ? COUNT_W'(MAX_SLICES) : slices_ff;
   assign nt = (stacks_ff == '0) ? COUNT_W'(1) :
               (stacks_ff > COUNT_W'(STACK_LIMIT)) ? COUNT_W'(STACK_LIMIT) : stacks_ff;

   assign rebuild = csr_we && ((csr_index == CSR_SLICES) || (csr_index == CSR_STACKS));

   usp_table_builder u_builder (
      .clock   (clock),
      .reset   (reset),
      .restart (rebuild),
      .ns      (ns),
      .nt      (nt),
      .wr      (tab_wr),
      .ready   (tables_ready)
   );

   // azimuth table, one entry per slice boundary
   usp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_theta_ram (
      .clock (clock),
      .we    (tab_wr.theta_we),
      .waddr (tab_wr.addr),
      .wdata (tab_wr.data),
      .raddr (theta_raddr),
      .rdata (theta_rbits)
   );

   // polar table, one entry per stack boundary
   usp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_phi_ram (
      .clock (clock),
      .we    (tab_wr.phi_we),
      .waddr (tab_wr.addr),
      .wdata (tab_wr.data),
      .raddr (phi_raddr),
      .rdata (phi_rbits)
   );

   // front: take and clamp face items into a short queue
   usp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .ns         (ns),
      .nt         (nt),
      .face_pop   (face_pop),
      .face_head  (face_head)
   );

   // back: six corners per face, pipelined scaling, output queue
   usp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tables_ready (tables_ready),
      .radius       (radius_ff),
      .face_head    (face_head),
      .face_pop     (face_pop),
      .theta_raddr  (theta_raddr),
      .phi_raddr    (phi_raddr),
      .theta_rd     (table_entry_type'(theta_rbits)),
      .phi_rd       (table_entry_type'(phi_rbits)),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/usp_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module usp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/usp_divider.sv
// iterative unsigned divider, four quotient bits per cycle
// depends on usp_pkg
`default_nettype none

module usp_divider import usp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIV_DEN_W-1:0] divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   always_comb begin
      logic [DIV_DEN_W:0]   tmp;
      logic [DIV_DEN_W-1:0] rem_v;
      logic [DIV_W-1:0]     num_v;
      logic [DIV_W-1:0]     quo_v;
      rem_v = rem_ff;
      num_v = num_ff;
      quo_v = quo_ff;
      // restoring steps on a narrow remainder
      for (int b = 0; b < DIV_BITS; b++) begin
         tmp   = {rem_v, num_v[DIV_W-1]};
         num_v = {num_v[DIV_W-2:0], 1'b0};
         if (tmp >= {1'b0, den_ff}) begin
            rem_v = DIV_DEN_W'(tmp - {1'b0, den_ff});
            quo_v = {quo_v[DIV_W-2:0], 1'b1};
         end else begin
            rem_v = tmp[DIV_DEN_W-1:0];
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in = num_v;
         quo_in = quo_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/usp_table_builder.sv
// fills the azimuth and polar angle tables with sine, cosine and texture coordinate
// depends on usp_pkg and usp_divider
`default_nettype none

module usp_table_builder import usp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               restart,
   input  wire logic [COUNT_W-1:0] ns,
   input  wire logic [COUNT_W-1:0] nt,
   output table_write_type         wr,
   output logic                    ready
);

   typedef enum logic [14:0] {
      BS_ANGLE_GO   = 15'b000000000000001,
      BS_ANGLE_WAIT = 15'b000000000000010,
      BS_TEX_GO     = 15'b000000000000100,
      BS_TEX_WAIT   = 15'b000000000001000,
      BS_MUL_LO     = 15'b000000000010000,
      BS_MUL_HI     = 15'b000000000100000,
      BS_SQUARE     = 15'b000000001000000,
      BS_SIN_MUL    = 15'b000000010000000,
      BS_SIN_GO     = 15'b000000100000000,
      BS_SIN_WAIT   = 15'b000001000000000,
      BS_COS_MUL    = 15'b000010000000000,
      BS_COS_GO     = 15'b000100000000000,
      BS_COS_WAIT   = 15'b001000000000000,
      BS_STORE      = 15'b010000000000000,
      BS_DONE       = 15'b100000000000000
   } build_state_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   localparam logic signed [35:0] ONE_S = 36'sd1073741824;

   build_state_type     state_ff, state_in;
   logic                phi_sel_ff, phi_sel_in;
   logic                ready_ff, ready_in;
   logic [TAB_AW-1:0]   idx_ff, idx_in;
   logic [31:0]         angle_ff, angle_in;
   logic [16:0]         tex_ff, tex_in;
   logic [45:0]         acc_ff, acc_in;
   logic [30:0]         x_ff, x_in;
   logic [31:0]         x2_ff, x2_in;
   logic [32:0]         term_ff, term_in;
   logic signed [35:0]  s_ff, s_in;
   logic signed [35:0]  c_ff, c_in;
   logic [3:0]          n_ff, n_in;

   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIV_DEN_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;

   logic [45:0]        p_lo;
   logic [44:0]        p_hi;
   logic [60:0]        p_full;
   logic [61:0]        p_sq;
   logic [64:0]        p_term;
   logic signed [35:0] q_term;
   logic [COUNT_W-1:0] limit;
   logic [30:0]        s_mag, c_mag;

   usp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // angle scaling r * pi/2 as two partial products
   assign p_lo   = 46'(angle_ff[29:0]) * 46'(HALF_PI_LO);
   assign p_hi   = 45'(angle_ff[29:0]) * 45'(HALF_PI_HI);
   assign p_full = {p_hi, 16'b0} + 61'(acc_ff);
   assign p_sq   = 62'(x_ff) * 62'(x_ff);
   assign p_term = 65'(term_ff) * 65'(x2_ff);
   assign q_term = $signed({3'b000, div_quotient[32:0]});
   assign limit  = phi_sel_ff ? nt : ns;

   function automatic logic [30:0] clamp_unit(input logic signed [35:0] v);
      if (v < 36'sd0) begin
         clamp_unit = '0;
      end else if (v > ONE_S) begin
         clamp_unit = ONE_Q30[30:0];
      end else begin
         clamp_unit = v[30:0];
      end
   endfunction

   assign s_mag = clamp_unit(s_ff);
   assign c_mag = clamp_unit(c_ff);

   always_comb begin
      logic sneg, cneg;
      logic [30:0] sm, cm;
      state_in     = state_ff;
      phi_sel_in   = phi_sel_ff;
      ready_in     = ready_ff;
      idx_in       = idx_ff;
      angle_in     = angle_ff;
      tex_in       = tex_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      term_in      = term_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      n_in         = n_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      wr           = '0;
      sneg         = 1'b0;
      cneg         = 1'b0;
      sm           = s_mag;
      cm           = c_mag;

      case (state_ff)
         BS_ANGLE_GO: begin
            div_start = 1'b1;
            if (phi_sel_ff) begin
               div_dividend = {3'b000, idx_ff, 32'b0} + DIV_W'(nt);
               div_divisor  = {nt, 1'b0};
            end else begin
               div_dividend = {3'b000, idx_ff, 32'b0} + DIV_W'(ns[COUNT_W-1:1]);
               div_divisor  = {1'b0, ns};
            end
            state_in = BS_ANGLE_WAIT;
         end
         BS_ANGLE_WAIT: begin
            if (div_done) begin
               angle_in = div_quotient[31:0];
               state_in = BS_TEX_GO;
            end
         end
         BS_TEX_GO: begin
            div_start    = 1'b1;
            div_dividend = {19'b0, idx_ff, 16'b0} + DIV_W'(limit[COUNT_W-1:1]);
            div_divisor  = {1'b0, limit};
            state_in     = BS_TEX_WAIT;
         end
         BS_TEX_WAIT: begin
            if (div_done) begin
               tex_in   = div_quotient[16:0];
               state_in = BS_MUL_LO;
            end
         end
         BS_MUL_LO: begin
            acc_in   = p_lo;
            state_in = BS_MUL_HI;
         end
         BS_MUL_HI: begin
            x_in     = p_full[60:30];
            state_in = BS_SQUARE;
         end
         BS_SQUARE: begin
            x2_in    = p_sq[61:30];
            term_in  = 33'(x_ff);
            s_in     = $signed({5'b0, x_ff});
            n_in     = 4'd1;
            state_in = BS_SIN_MUL;
         end
         BS_SIN_MUL: begin
            term_in  = p_term[62:30];
            state_in = BS_SIN_GO;
         end
         BS_SIN_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(term_ff);
            div_divisor  = sin_divisor(n_ff);
            state_in     = BS_SIN_WAIT;
         end
         BS_SIN_WAIT: begin
            if (div_done) begin
               term_in = div_quotient[32:0];
               s_in    = n_ff[0] ? (s_ff - q_term) : (s_ff + q_term);
               if (n_ff == SERIES_TERMS) begin
                  term_in  = ONE_Q30;
                  c_in     = $signed({3'b000, ONE_Q30});
                  n_in     = 4'd1;
                  state_in = BS_COS_MUL;
               end else begin
                  n_in     = n_ff + 4'd1;
                  state_in = BS_SIN_MUL;
               end
            end
         end
         BS_COS_MUL: begin
            term_in  = p_term[62:30];
            state_in = BS_COS_GO;
         end
         BS_COS_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(term_ff);
            div_divisor  = cos_divisor(n_ff);
            state_in     = BS_COS_WAIT;
         end
         BS_COS_WAIT: begin
            if (div_done) begin
               term_in = div_quotient[32:0];
               c_in    = n_ff[0] ? (c_ff - q_term) : (c_ff + q_term);
               if (n_ff == SERIES_TERMS) begin
                  state_in = BS_STORE;
               end else begin
                  n_in     = n_ff + 4'd1;
                  state_in = BS_COS_MUL;
               end
            end
         end
         BS_STORE: begin
            // fold the quadrant back in
            case (quadrant_type'(angle_ff[31:30]))
               QUAD_0: begin
                  sm = s_mag; sneg = 1'b0; cm = c_mag; cneg = 1'b0;
               end
               QUAD_1: begin
                  sm = c_mag; sneg = 1'b0; cm = s_mag; cneg = 1'b1;
               end
               QUAD_2: begin
                  sm = s_mag; sneg = 1'b1; cm = c_mag; cneg = 1'b1;
               end
               QUAD_3: begin
                  sm = c_mag; sneg = 1'b1; cm = s_mag; cneg = 1'b0;
               end
               default: begin
                  sm = s_mag; sneg = 1'b0; cm = c_mag; cneg = 1'b0;
               end
            endcase
            wr.theta_we     = !phi_sel_ff;
            wr.phi_we       = phi_sel_ff;
            wr.addr         = idx_ff;
            wr.data.sin_neg = sneg && (sm != '0);
            wr.data.sin_mag = sm;
            wr.data.cos_neg = cneg && (cm != '0);
            wr.data.cos_mag = cm;
            wr.data.tex     = tex_ff;
            if (idx_ff == limit) begin
               idx_in = '0;
               if (phi_sel_ff) begin
                  ready_in = 1'b1;
                  state_in = BS_DONE;
               end else begin
                  phi_sel_in = 1'b1;
                  state_in   = BS_ANGLE_GO;
               end
            end else begin
               idx_in   = idx_ff + TAB_AW'(1);
               state_in = BS_ANGLE_GO;
            end
         end
         BS_DONE: begin
            state_in = BS_DONE;
         end
         default: begin
            state_in   = BS_ANGLE_GO;
            phi_sel_in = 1'b0;
            idx_in     = '0;
            ready_in   = 1'b0;
         end
      endcase

      // a count change rebuilds both tables from the start
      if (restart) begin
         state_in   = BS_ANGLE_GO;
         phi_sel_in = 1'b0;
         idx_in     = '0;
         ready_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BS_ANGLE_GO;
         phi_sel_ff <= 1'b0;
         ready_ff   <= 1'b0;
         idx_ff     <= '0;
         n_ff       <= 4'd1;
      end else begin
         state_ff   <= state_in;
         phi_sel_ff <= phi_sel_in;
         ready_ff   <= ready_in;
         idx_ff     <= idx_in;
         n_ff       <= n_in;
      end
      angle_ff <= angle_in;
      tex_ff   <= tex_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      term_ff  <= term_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
   end

   assign ready = ready_ff;

endmodule

`default_nettype wire

>>> rtl/usp_front.sv
// request side: accepts face items, clamps the indices and queues them
// depends on usp_pkg
`default_nettype none

module usp_front import usp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [15:0]        req_tdata,
   input  wire logic [COUNT_W-1:0] ns,
   input  wire logic [COUNT_W-1:0] nt,
   input  wire logic               face_pop,
   output face_q_type              face_head
);

   face_type               qmem_ff [FACE_Q_DEPTH];
   logic [FACE_Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FACE_Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FACE_Q_AW:0]     cnt_ff, cnt_in;
   logic                   accept;
   logic [COUNT_W-1:0]     ns_m1, nt_m1;
   face_type               clamped;

   assign ns_m1 = ns - COUNT_W'(1);
   assign nt_m1 = nt - COUNT_W'(1);

   always_comb begin
      clamped.x = (COUNT_W'(req_tdata[7:0]) > ns_m1) ? ns_m1[7:0] : req_tdata[7:0];
      clamped.y = (COUNT_W'(req_tdata[15:8]) > nt_m1) ? nt_m1[7:0] : req_tdata[15:8];
   end

   assign req_tready = (cnt_ff != (FACE_Q_AW + 1)'(FACE_Q_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + FACE_Q_AW'(1);
      end
      if (face_pop) begin
         rd_ptr_in = rd_ptr_ff + FACE_Q_AW'(1);
      end
      case ({accept, face_pop})
         2'b10:   cnt_in = cnt_ff + (FACE_Q_AW + 1)'(1);
         2'b01:   cnt_in = cnt_ff - (FACE_Q_AW + 1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (accept) begin
         qmem_ff[wr_ptr_ff] <= clamped;
      end
   end

   assign face_head.valid = (cnt_ff != '0);
   assign face_head.face  = qmem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> rtl/usp_back.sv
// vertex side: walks the six corners, looks up the angle tables, scales and queues results
// depends on usp_pkg
`default_nettype none

module usp_back import usp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tables_ready,
   input  wire logic [15:0]       radius,
   input  face_q_type             face_head,
   output logic                   face_pop,
   output logic [TAB_AW-1:0]      theta_raddr,
   output logic [TAB_AW-1:0]      phi_raddr,
   input  table_entry_type        theta_rd,
   input  table_entry_type        phi_rd,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [135:0]           rsp_tdata,
   output logic                   rsp_tlast
);

   logic [2:0]        slot_ff, slot_in;
   logic              v1_ff, v2_ff;
   logic [2:0]        slot1_ff, slot2_ff;
   logic              issue;
   logic [OUT_CW-1:0] pending;

   logic [31:0] rs_ff;
   logic [16:0] pz_ff;
   logic [15:0] nx_ff, ny_ff, nz_ff;
   logic [30:0] ct_ff, st_ff;
   logic        xneg_ff, yneg_ff, zneg_ff;
   logic [16:0] texu_ff, texv_ff;

   logic [46:0] p_rs, p_pz;
   logic [61:0] p_nx, p_ny;
   logic [31:0] s_nz;
   logic [62:0] p_px, p_py;
   logic [16:0] px, py;
   rsp_type     vtx;

   rsp_type           out_mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CW-1:0] out_cnt_ff, out_cnt_in;
   logic              out_pop;
   rsp_type           head;

   // keep room in the output queue for every corner already in flight
   assign pending = out_cnt_ff + OUT_CW'(v1_ff) + OUT_CW'(v2_ff);
   assign issue   = face_head.valid && tables_ready && (pending < OUT_CW'(OUT_DEPTH));
   assign face_pop = issue && (slot_ff == LAST_SLOT);

   assign theta_raddr = TAB_AW'(face_head.face.x) + TAB_AW'(corner_dx(slot_ff));
   assign phi_raddr   = TAB_AW'(face_head.face.y) + TAB_AW'(corner_dy(slot_ff));

   always_comb begin
      slot_in = slot_ff;
      if (issue) begin
         slot_in = (slot_ff == LAST_SLOT) ? FIRST_SLOT : slot_ff + 3'd1;
      end
   end

   // first product stage
   assign p_rs = 47'(radius) * 47'(phi_rd.sin_mag);
   assign p_pz = 47'(radius) * 47'(phi_rd.cos_mag) + 47'(1) * (47'(1) << 29);
   assign p_nx = 62'(phi_rd.sin_mag) * 62'(theta_rd.cos_mag) + (62'(1) << 45);
   assign p_ny = 62'(phi_rd.sin_mag) * 62'(theta_rd.sin_mag) + (62'(1) << 45);
   assign s_nz = 32'(phi_rd.cos_mag) + (32'(1) << 15);

   // second product stage
   assign p_px = 63'(rs_ff) * 63'(ct_ff) + (63'(1) << 44);
   assign p_py = 63'(rs_ff) * 63'(st_ff) + (63'(1) << 44);
   assign px   = p_px[61:45];
   assign py   = p_py[61:45];

   always_comb begin
      vtx.pos_x  = xneg_ff ? (17'd0 - px) : px;
      vtx.pos_y  = yneg_ff ? (17'd0 - py) : py;
      vtx.pos_z  = zneg_ff ? (17'd0 - pz_ff) : pz_ff;
      vtx.tex_u  = texu_ff;
      vtx.tex_v  = texv_ff;
      vtx.norm_x = xneg_ff ? (16'd0 - nx_ff) : nx_ff;
      vtx.norm_y = yneg_ff ? (16'd0 - ny_ff) : ny_ff;
      vtx.norm_z = zneg_ff ? (16'd0 - nz_ff) : nz_ff;
      vtx.slot   = slot2_ff;
      vtx.last   = (slot2_ff == LAST_SLOT);
   end

   assign out_pop = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({v2_ff, out_pop})
         2'b10:   out_cnt_in = out_cnt_ff + OUT_CW'(1);
         2'b01:   out_cnt_in = out_cnt_ff - OUT_CW'(1);
         default: out_cnt_in = out_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= FIRST_SLOT;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         slot_ff    <= slot_in;
         v1_ff      <= issue;
         v2_ff      <= v1_ff;
         out_cnt_ff <= out_cnt_in;
         if (v2_ff) begin
            out_wr_ff <= out_wr_ff + OUT_AW'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + OUT_AW'(1);
         end
      end
      slot1_ff <= slot_ff;
      slot2_ff <= slot1_ff;
      rs_ff    <= p_rs[46:15];
      pz_ff    <= p_pz[46:30];
      nx_ff    <= p_nx[61:46];
      ny_ff    <= p_ny[61:46];
      nz_ff    <= s_nz[31:16];
      ct_ff    <= theta_rd.cos_mag;
      st_ff    <= theta_rd.sin_mag;
      xneg_ff  <= phi_rd.sin_neg ^ theta_rd.cos_neg;
      yneg_ff  <= phi_rd.sin_neg ^ theta_rd.sin_neg;
      zneg_ff  <= phi_rd.cos_neg;
      texu_ff  <= theta_rd.tex;
      texv_ff  <= phi_rd.tex;
      if (v2_ff) begin
         out_mem_ff[out_wr_ff] <= vtx;
      end
   end

   assign head       = out_mem_ff[out_rd_ff];
   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {head.slot, head.norm_z, head.norm_y, head.norm_x, head.tex_v,
                        head.tex_u, head.pos_z, head.pos_y, head.pos_x};

endmodule

`default_nettype wire

>>> rtl/usp_checker.sv
// port-level checks on the vertex stream, bound to the top level
// depends on usp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module usp_checker import usp_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [135:0] rsp_tdata,
   input wire logic         rsp_tlast
);

   logic [2:0] slot;
   assign slot = rsp_tdata[SLOT_LSB +: 3];

   // a stalled vertex holds
   `USP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // tlast marks the sixth corner only
   `USP_ASSERT_IMPLY(a_last_slot, clock, reset, rsp_tvalid, rsp_tlast == (slot == LAST_SLOT))

   // a face starts again at the first corner
   `USP_ASSERT_NEXT(a_face_restart, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid || (slot == FIRST_SLOT))

   // corners of one face come in order
   `USP_ASSERT_NEXT(a_slot_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !rsp_tvalid || (slot == $past(slot) + 3'd1))

endmodule

bind uv_sphere_face_vertex_generator usp_checker u_checker (.*);

`default_nettype wire
